### src/ddpp_pkg.sv
// ============================================================================
// ddpp_pkg - shared types and constants of the drive distance power profiler
// Field widths, configuration register indexes and the pipeline control word.
// ============================================================================
package ddpp_pkg;

   localparam int MOTORS_PER_SIDE = 4;
   localparam int MOTOR_COUNT     = 2 * MOTORS_PER_SIDE;
   localparam int AVG_SHIFT       = $clog2(MOTOR_COUNT);

   localparam int TARGET_W = 24;
   localparam int POWER_W  = 7;
   localparam int DRIVE_W  = 8;
   localparam int QUOT_W   = POWER_W;
   localparam int PROD_W   = POWER_W + TARGET_W;
   localparam int NUM_W    = PROD_W + TARGET_W + 2;
   localparam int TSQ_W    = 2 * TARGET_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TARGET_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TICKS   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT_POWER = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POWER      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER      = CSR_IDX_W'(4);

   localparam logic MODE_CONSTANT  = 1'b0;
   localparam logic MODE_PARABOLIC = 1'b1;

   typedef struct packed {
      logic vld;
      logic done;
   } ctl_type;

endpackage

### src/ddpp_dist.sv
// ============================================================================
// ddpp_dist - distance front end
// Sums the encoder positions per side, then in total, and takes the magnitude
// of the average (truncated toward zero) as the distance travelled.
// ============================================================================
module ddpp_dist #(
   parameter int POS_WIDTH = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  logic signed [POS_WIDTH-1:0] pos [ddpp_pkg::MOTOR_COUNT],
   output logic                        out_vld,
   output logic [POS_WIDTH-1:0]        travel
);
   import ddpp_pkg::*;

   localparam int SUM_W = POS_WIDTH + AVG_SHIFT;

   logic                    vld1_ff, vld2_ff, vld3_ff;
   logic signed [SUM_W-1:0] lsum_in, rsum_in, lsum_ff, rsum_ff;
   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic [SUM_W-1:0]        mag;
   logic [POS_WIDTH-1:0]    dist_in, dist_ff;

   // side sums
   always_comb begin
      lsum_in = '0;
      rsum_in = '0;
      for (int i = 0; i < MOTORS_PER_SIDE; i++) begin
         lsum_in = lsum_in + SUM_W'(pos[i]);
         rsum_in = rsum_in + SUM_W'(pos[i + MOTORS_PER_SIDE]);
      end
   end

   assign sum_in = lsum_ff + rsum_ff;

   // magnitude of the sum, then drop the low bits: |trunc(sum/N)| == |sum| >> log2(N)
   assign mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign dist_in = mag[SUM_W-1:AVG_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      lsum_ff <= lsum_in;
      rsum_ff <= rsum_in;
      sum_ff  <= sum_in;
      dist_ff <= dist_in;
   end

   assign out_vld = vld3_ff;
   assign travel  = dist_ff;

endmodule

### src/ddpp_div_step.sv
// ============================================================================
// ddpp_div_step - one restoring division stage
// Resolves one quotient bit of numerator / target squared per cycle.
// ============================================================================
module ddpp_div_step #(
   parameter int BIT = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ddpp_pkg::ctl_type              ctl_i,
   input  logic [ddpp_pkg::NUM_W-1:0]     rem_i,
   input  logic [ddpp_pkg::QUOT_W-1:0]    quot_i,
   input  logic [ddpp_pkg::TSQ_W-1:0]     tsq,
   output ddpp_pkg::ctl_type              ctl_o,
   output logic [ddpp_pkg::NUM_W-1:0]     rem_o,
   output logic [ddpp_pkg::QUOT_W-1:0]    quot_o
);
   import ddpp_pkg::*;

   ctl_type            ctl_ff;
   logic [NUM_W-1:0]   divisor;
   logic [NUM_W-1:0]   rem_in, rem_ff;
   logic [QUOT_W-1:0]  quot_in, quot_ff;

   assign divisor = NUM_W'(tsq) << BIT;

   always_comb begin
      rem_in  = rem_i;
      quot_in = quot_i;
      if (rem_i >= divisor) begin
         rem_in  = rem_i - divisor;
         quot_in = quot_i | (QUOT_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;

endmodule

### src/ddpp_ramp.sv
// ============================================================================
// ddpp_ramp - parabolic ramp datapath
// Compares distance with target, forms 4*A*d*(T-d) over two multiply stages
// and divides it by T*T in a chain of one-bit division stages.
// ============================================================================
module ddpp_ramp #(
   parameter int POS_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_vld,
   input  logic [POS_WIDTH-1:0]           travel,
   input  logic [ddpp_pkg::TARGET_W-1:0]  t_abs,
   input  logic [ddpp_pkg::TSQ_W-1:0]     tsq,
   input  logic [ddpp_pkg::POWER_W-1:0]   amp,
   output ddpp_pkg::ctl_type              out_ctl,
   output logic [ddpp_pkg::QUOT_W-1:0]    quot
);
   import ddpp_pkg::*;

   localparam int EXT_W = (POS_WIDTH > TARGET_W) ? POS_WIDTH : TARGET_W;

   ctl_type              ctl4_in, ctl4_ff, ctl5_ff;
   logic [EXT_W-1:0]     d_ext, t_ext;
   logic [TARGET_W-1:0]  d_t;
   logic [PROD_W-1:0]    ad_in, ad_ff;
   logic [TARGET_W-1:0]  tmd_in, tmd_ff;
   logic [NUM_W-1:0]     num_in, num_ff;

   ctl_type              ctl_c  [QUOT_W+1];
   logic [NUM_W-1:0]     rem_c  [QUOT_W+1];
   logic [QUOT_W-1:0]    quot_c [QUOT_W+1];

   // done check; below the target d fits the target width
   assign d_ext        = EXT_W'(travel);
   assign t_ext        = EXT_W'(t_abs);
   assign d_t          = d_ext[TARGET_W-1:0];
   assign ctl4_in.vld  = in_vld;
   assign ctl4_in.done = (d_ext >= t_ext);
   assign ad_in        = PROD_W'(amp) * PROD_W'(d_t);
   assign tmd_in       = t_abs - d_t;

   assign num_in = {(NUM_W-2)'((NUM_W-2)'(ad_ff) * (NUM_W-2)'(tmd_ff)), 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl4_ff <= ctl4_in;
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      ad_ff  <= ad_in;
      tmd_ff <= tmd_in;
      num_ff <= num_in;
   end

   assign ctl_c[0]  = ctl5_ff;
   assign rem_c[0]  = num_ff;
   assign quot_c[0] = '0;

   // most significant quotient bit first
   for (genvar g = 0; g < QUOT_W; g++) begin : g_div
      ddpp_div_step #(
         .BIT (QUOT_W - 1 - g)
      ) u_step (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl_c[g]),
         .rem_i  (rem_c[g]),
         .quot_i (quot_c[g]),
         .tsq    (tsq),
         .ctl_o  (ctl_c[g+1]),
         .rem_o  (rem_c[g+1]),
         .quot_o (quot_c[g+1])
      );
   end

   assign out_ctl = ctl_c[QUOT_W];
   assign quot    = quot_c[QUOT_W];

endmodule

### src/drive_distance_power_profiler_unit.sv
// ============================================================================
// drive_distance_power_profiler_unit - drive distance power profiler
// Turns one sample of eight encoder positions into a signed drive power
// command (constant or parabolic ramp) and a done flag.
// ============================================================================
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   request   start / busy           req_left_pos_a..d, req_right_pos_a..d
//   response  rsp_valid (strobe)     rsp_left_drive, rsp_right_drive,
//                                    rsp_done_res
//   csr       csr_we                 csr_index, csr_wdata
//
// One transaction enters per cycle; busy stays low. Each response passes
// through the summing and averaging registers, 2 multiply stages, 7 division
// stages (one quotient bit each) and the output register.
// Synchronous reset clears the valid pipeline and the configuration registers.
// The receiver cannot stall, so the pipeline advances every cycle.
//
module drive_distance_power_profiler_unit #(
   parameter int POS_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_a,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_b,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_c,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_d,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_a,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_b,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_c,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_d,

   output logic                                 rsp_valid,
   output logic signed [ddpp_pkg::DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [ddpp_pkg::DRIVE_W-1:0]  rsp_right_drive,
   output logic                                 rsp_done_res,

   input  logic                                 csr_we,
   input  logic [ddpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddpp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ddpp_pkg::*;

   localparam int LATENCY = 13;

   // configuration registers
   logic                        mode_in, mode_ff;
   logic signed [TARGET_W-1:0]  target_in, target_ff;
   logic [POWER_W-1:0]          const_in, const_ff;
   logic [POWER_W-1:0]          min_in, min_ff;
   logic [POWER_W-1:0]          max_in, max_ff;

   // values derived from configuration
   logic [TARGET_W-1:0]         t_abs;
   logic [TSQ_W-1:0]            tsq_ff;
   logic [POWER_W-1:0]          amp;
   logic                        dir_pos;

   logic                        accept;
   logic signed [POS_WIDTH-1:0] pos [MOTOR_COUNT];
   logic                        dist_vld;
   logic [POS_WIDTH-1:0]        travel;
   ctl_type                     ramp_ctl;
   logic [QUOT_W-1:0]           quot;

   logic [DRIVE_W-1:0]          mag;
   logic [DRIVE_W-1:0]          drive_in, drive_ff;
   logic                        done_in, done_ff;
   logic                        valid_ff;

   // never back-pressure: one transaction per cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- csr
   always_comb begin
      mode_in   = mode_ff;
      target_in = target_ff;
      const_in  = const_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROFILE_MODE:   mode_in   = csr_wdata[0];
            CSR_TARGET_TICKS:   target_in = TARGET_W'(csr_wdata);
            CSR_CONSTANT_POWER: const_in  = csr_wdata[POWER_W-1:0];
            CSR_MIN_POWER:      min_in    = csr_wdata[POWER_W-1:0];
            CSR_MAX_POWER:      max_in    = csr_wdata[POWER_W-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_CONSTANT;
         target_ff <= '0;
         const_ff  <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         const_ff  <= const_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
      end
   end

   // |target|: the most negative target maps to 2^23, which still fits
   assign t_abs   = target_ff[TARGET_W-1] ? TARGET_W'(-target_ff) : TARGET_W'(target_ff);
   // forward only for a strictly positive target; zero counts as reverse
   assign dir_pos = !target_ff[TARGET_W-1] && (target_ff != '0);
   // ramp amplitude, clamped at zero when max sits below min
   assign amp     = (max_ff > min_ff) ? (max_ff - min_ff) : '0;

   // target squared only changes with configuration; register it once
   always_ff @(posedge clock) begin
      tsq_ff <= TSQ_W'(t_abs) * TSQ_W'(t_abs);
   end

   // ---------------------------------------------------------------- datapath
   assign pos[0] = req_left_pos_a;
   assign pos[1] = req_left_pos_b;
   assign pos[2] = req_left_pos_c;
   assign pos[3] = req_left_pos_d;
   assign pos[4] = req_right_pos_a;
   assign pos[5] = req_right_pos_b;
   assign pos[6] = req_right_pos_c;
   assign pos[7] = req_right_pos_d;

   ddpp_dist #(
      .POS_WIDTH (POS_WIDTH)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (accept),
      .pos     (pos),
      .out_vld (dist_vld),
      .travel  (travel)
   );

   ddpp_ramp #(
      .POS_WIDTH (POS_WIDTH)
   ) u_ramp (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (dist_vld),
      .travel  (travel),
      .t_abs   (t_abs),
      .tsq     (tsq_ff),
      .amp     (amp),
      .out_ctl (ramp_ctl),
      .quot    (quot)
   );

   // ---------------------------------------------------------------- output
   // quotient never exceeds the amplitude, so quot + min stays within 127
   always_comb begin
      if (mode_ff == MODE_PARABOLIC) begin
         mag = DRIVE_W'(quot) + DRIVE_W'(min_ff);
      end else begin
         mag = DRIVE_W'(const_ff);
      end
      if (ramp_ctl.done) begin
         drive_in = '0;
      end else if (dir_pos) begin
         drive_in = mag;
      end else begin
         drive_in = DRIVE_W'(-mag);
      end
      done_in = ramp_ctl.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ramp_ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
      done_ff  <= done_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_left_drive  = drive_ff;
   assign rsp_right_drive = drive_ff;
   assign rsp_done_res    = done_ff;

   // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("response missing after accepted request");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without matching request");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_left_drive == '0 && rsp_right_drive == '0))
      else $error("nonzero drive while done");

   a_sides_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_drive == rsp_right_drive))
      else $error("left and right drive differ");
`endif

endmodule

### dv/ddpp_drive_checker.sv
// ============================================================================
// ddpp_drive_checker - drive command predictor and scoreboard
// Watches the request, response and csr channels of the drive distance power
// profiler, keeps its own copy of the profile registers, predicts the drive
// command of every accepted sample and compares each strobed response with
// the oldest prediction, field by field.
// ============================================================================
module ddpp_drive_checker #(
   parameter int POS_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_a,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_b,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_c,
   input  logic signed [POS_WIDTH-1:0]          req_left_pos_d,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_a,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_b,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_c,
   input  logic signed [POS_WIDTH-1:0]          req_right_pos_d,
   input  logic                                 rsp_valid,
   input  logic signed [ddpp_pkg::DRIVE_W-1:0]  rsp_left_drive,
   input  logic signed [ddpp_pkg::DRIVE_W-1:0]  rsp_right_drive,
   input  logic                                 rsp_done_res,
   input  logic                                 csr_we,
   input  logic [ddpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddpp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   outstanding,
   output int                                   results_checked,
   output int                                   fail_count
);
   import ddpp_pkg::*;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      done;
   } drive_command_type;

   // shadow copy of the profile registers
   logic                       profile_mode;
   logic signed [TARGET_W-1:0] target_ticks;
   logic [POWER_W-1:0]         constant_power;
   logic [POWER_W-1:0]         min_power;
   logic [POWER_W-1:0]         max_power;

   drive_command_type expected_drive_q [$];
   drive_command_type oldest;

   task automatic report_mismatch(input string what);
      $display("[%0t] drive mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic longint sum_positions();
      return longint'(req_left_pos_a) + longint'(req_left_pos_b) +
             longint'(req_left_pos_c) + longint'(req_left_pos_d) +
             longint'(req_right_pos_a) + longint'(req_right_pos_b) +
             longint'(req_right_pos_c) + longint'(req_right_pos_d);
   endfunction

   // average toward zero, fold to a distance, then constant or parabolic power
   function automatic drive_command_type predict_drive_command(input longint position_sum);
      longint            travelled;
      longint            goal;
      longint            span;
      longint unsigned   amp;
      longint unsigned   num;
      longint unsigned   den;
      longint            magnitude;
      drive_command_type cmd;
      travelled = position_sum / MOTOR_COUNT;
      if (travelled < 0)
         travelled = -travelled;
      goal = longint'(target_ticks);
      span = (goal < 0) ? -goal : goal;
      cmd  = '0;
      if (travelled >= span) begin
         cmd.done = 1'b1;
      end else begin
         if (profile_mode == MODE_CONSTANT) begin
            magnitude = longint'(constant_power);
         end else begin
            // max below min collapses the ramp to a flat min_power
            amp = (max_power > min_power) ? longint'(max_power - min_power) : 0;
            num = 4 * amp * longint'(travelled) * longint'(span - travelled);
            den = longint'(span) * longint'(span);
            magnitude = longint'(num / den) + longint'(min_power);
         end
         // a zero or negative target drives backward, min_power term included
         cmd.left_drive  = DRIVE_W'((goal > 0) ? magnitude : -magnitude);
         cmd.right_drive = cmd.left_drive;
      end
      return cmd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         profile_mode   = MODE_CONSTANT;
         target_ticks   = '0;
         constant_power = '0;
         min_power      = '0;
         max_power      = '0;
         expected_drive_q.delete();
      end else begin
         // retire the oldest prediction before queuing a new one
         if (rsp_valid) begin
            if (expected_drive_q.size() == 0) begin
               report_mismatch("response strobe with no transaction outstanding");
            end else begin
               oldest = expected_drive_q.pop_front();
               results_checked++;
               if (rsp_left_drive !== oldest.left_drive)
                  report_mismatch($sformatf("left_drive %0d, expected %0d",
                                            rsp_left_drive, oldest.left_drive));
               if (rsp_right_drive !== oldest.right_drive)
                  report_mismatch($sformatf("right_drive %0d, expected %0d",
                                            rsp_right_drive, oldest.right_drive));
               if (rsp_done_res !== oldest.done)
                  report_mismatch($sformatf("done_res %b, expected %b",
                                            rsp_done_res, oldest.done));
            end
         end
         if (start && !busy)
            expected_drive_q.push_back(predict_drive_command(sum_positions()));
         if (csr_we) begin
            case (csr_index)
               CSR_PROFILE_MODE:   profile_mode   = csr_wdata[0];
               CSR_TARGET_TICKS:   target_ticks   = csr_wdata[TARGET_W-1:0];
               CSR_CONSTANT_POWER: constant_power = csr_wdata[POWER_W-1:0];
               CSR_MIN_POWER:      min_power      = csr_wdata[POWER_W-1:0];
               CSR_MAX_POWER:      max_power      = csr_wdata[POWER_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_drive_q.size();
   end

endmodule

### dv/tb.sv
// ============================================================================
// tb - testbench of the drive distance power profiler
// Programs a series of motion profiles, feeds encoder samples through the
// start/busy handshake and leaves all checking to the drive checker. A short
// directed pass hits the field extremes and the corner cases, then random
// samples run under three sender idling patterns.
// ============================================================================
module tb;
   import ddpp_pkg::*;

   localparam int POS_W        = 24;
   localparam int MAX_POS      = 8388607;
   localparam int MIN_POS      = -8388608;
   localparam int STALL_LIMIT  = 1000;  // cycles without any transaction
   localparam int DRAIN_CYCLES = 20;    // pipeline is 13 deep
   localparam int RANDOM_RUN   = 100;   // samples per random profile
   localparam int RANDOM_SETS  = 4;     // profiles per idling pattern

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [POS_W-1:0]   req_left_pos_a  = '0;
   logic signed [POS_W-1:0]   req_left_pos_b  = '0;
   logic signed [POS_W-1:0]   req_left_pos_c  = '0;
   logic signed [POS_W-1:0]   req_left_pos_d  = '0;
   logic signed [POS_W-1:0]   req_right_pos_a = '0;
   logic signed [POS_W-1:0]   req_right_pos_b = '0;
   logic signed [POS_W-1:0]   req_right_pos_c = '0;
   logic signed [POS_W-1:0]   req_right_pos_d = '0;
   logic                      rsp_valid;
   logic signed [DRIVE_W-1:0] rsp_left_drive;
   logic signed [DRIVE_W-1:0] rsp_right_drive;
   logic                      rsp_done_res;
   logic                      csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_PROFILE_MODE;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int outstanding;
   int results_checked;
   int fail_count;

   int sample_pos [8];       // left a..d, then right a..d
   int idle_pct      = 0;
   int active_target = 0;
   int samples_sent  = 0;
   int profiles_used = 0;
   int stall_cycles  = 0;

   always #6 clock = ~clock;

   drive_distance_power_profiler_unit #(
      .POS_WIDTH(POS_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_left_pos_a  (req_left_pos_a),
      .req_left_pos_b  (req_left_pos_b),
      .req_left_pos_c  (req_left_pos_c),
      .req_left_pos_d  (req_left_pos_d),
      .req_right_pos_a (req_right_pos_a),
      .req_right_pos_b (req_right_pos_b),
      .req_right_pos_c (req_right_pos_c),
      .req_right_pos_d (req_right_pos_d),
      .rsp_valid       (rsp_valid),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_done_res    (rsp_done_res),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ddpp_drive_checker #(
      .POS_WIDTH(POS_W)
   ) drive_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_left_pos_a  (req_left_pos_a),
      .req_left_pos_b  (req_left_pos_b),
      .req_left_pos_c  (req_left_pos_c),
      .req_left_pos_d  (req_left_pos_d),
      .req_right_pos_a (req_right_pos_a),
      .req_right_pos_b (req_right_pos_b),
      .req_right_pos_c (req_right_pos_c),
      .req_right_pos_d (req_right_pos_d),
      .rsp_valid       (rsp_valid),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_done_res    (rsp_done_res),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .fail_count      (fail_count)
   );

   // Watchdog: restart the count on any transaction on any channel, give up
   // once the whole bench has been silent for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("drive_distance_power_profiler_unit test failed");
         $finish;
      end
   end

   function automatic int clamp_pos(input longint value);
      if (value > MAX_POS)
         return MAX_POS;
      if (value < MIN_POS)
         return MIN_POS;
      return int'(value);
   endfunction

   function automatic void fill_uniform(input int value);
      foreach (sample_pos[i])
         sample_pos[i] = value;
   endfunction

   // Scatter the eight encoders around one travel value, as real wheels do.
   function automatic void fill_around(input longint center, input int spread);
      foreach (sample_pos[i])
         sample_pos[i] = clamp_pos(center + longint'($urandom_range(2 * spread)) - spread);
   endfunction

   // Mostly well-formed moves that sweep the distance from zero to past the
   // target, a slice pinned on the done boundary, and some raw noise.
   function automatic void build_random_sample();
      int     pick;
      longint span;
      longint center;
      int     spread;
      pick   = $urandom_range(99);
      span   = (active_target < 0) ? -longint'(active_target) : longint'(active_target);
      spread = (pick < 70) ? $urandom_range(16) : $urandom_range(4096);
      if (pick < 15) begin
         foreach (sample_pos[i])
            sample_pos[i] = int'($urandom_range(16777215)) - 8388608;
      end else begin
         if (pick < 25) begin
            center = (span > 0 && $urandom_range(1)) ? span - 1 : span;
            spread = 0;
         end else begin
            center = longint'($urandom_range(32'(span + span / 4 + 1)));
         end
         if ($urandom_range(1))
            center = -center;
         fill_around(center, spread);
      end
   endfunction

   function automatic int random_target();
      case ($urandom_range(7))
         0:       return 0;
         1:       return MIN_POS;
         2:       return MAX_POS;
         3:       return $urandom_range(1) ? 1 : -1;
         4:       return int'($urandom_range(400)) - 200;
         default: return int'($urandom_range(16777215)) - 8388608;
      endcase
   endfunction

   function automatic int random_power();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 127;
         default: return $urandom_range(127);
      endcase
   endfunction

   // Present one sample, idling first as the current pattern asks, and hold
   // it until the handshake takes it. Leave start high on return so a
   // back-to-back transaction needs no second edit in the same step.
   task automatic send_sample();
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_left_pos_a  <= POS_W'(sample_pos[0]);
      req_left_pos_b  <= POS_W'(sample_pos[1]);
      req_left_pos_c  <= POS_W'(sample_pos[2]);
      req_left_pos_d  <= POS_W'(sample_pos[3]);
      req_right_pos_a <= POS_W'(sample_pos[4]);
      req_right_pos_b <= POS_W'(sample_pos[5]);
      req_right_pos_c <= POS_W'(sample_pos[6]);
      req_right_pos_d <= POS_W'(sample_pos[7]);
      do @(posedge clock); while (busy);
      samples_sent++;
   endtask

   // Drop start and hold off until every predicted command has come back.
   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic put_register(input logic [CSR_IDX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Reprogram only on an empty pipeline, then release the write port.
   task automatic program_profile(input logic mode, input int target, input int const_pwr,
                                  input int min_pwr, input int max_pwr);
      wait_all_results();
      put_register(CSR_PROFILE_MODE,   CSR_DATA_W'(mode));
      put_register(CSR_TARGET_TICKS,   CSR_DATA_W'(target));
      put_register(CSR_CONSTANT_POWER, CSR_DATA_W'(const_pwr));
      put_register(CSR_MIN_POWER,      CSR_DATA_W'(min_pwr));
      put_register(CSR_MAX_POWER,      CSR_DATA_W'(max_pwr));
      csr_we <= 1'b0;
      active_target = target;
      profiles_used++;
   endtask

   initial begin
      int patterns [3];
      patterns = '{12, 81, 0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed pass, no idling ---
      // reset profile: zero target, so every sample is done at once
      fill_uniform(0);
      send_sample();
      fill_uniform(MAX_POS);
      send_sample();

      // constant power, forward move of 1000 ticks
      program_profile(MODE_CONSTANT, 1000, 127, 0, 127);
      fill_uniform(0);
      send_sample();
      fill_uniform(999);
      send_sample();
      fill_uniform(1000);           // exactly at the target
      send_sample();
      fill_uniform(-1000);          // reverse travel still counts as distance
      send_sample();
      sample_pos = '{-1, -1, -1, -1, -1, -1, -1, 0};   // average truncates to 0
      send_sample();
      sample_pos = '{-2, -2, -2, -2, -2, -2, -2, -1};  // average truncates to -1
      send_sample();
      fill_uniform(MIN_POS);
      send_sample();

      // parabolic ramp, longest backward move
      program_profile(MODE_PARABOLIC, MIN_POS, 0, 5, 127);
      fill_uniform(0);
      send_sample();
      fill_uniform(-4194304);       // mid-distance peak
      send_sample();
      fill_uniform(2097152);        // quarter distance
      send_sample();
      fill_uniform(MAX_POS);        // one tick short of the target
      send_sample();
      fill_uniform(MIN_POS);
      send_sample();

      // peak below minimum: flat ramp, longest forward move
      program_profile(MODE_PARABOLIC, MAX_POS, 0, 127, 0);
      fill_uniform(4194303);
      send_sample();
      fill_uniform(0);
      send_sample();

      // one-tick backward move, zero and full constant power
      program_profile(MODE_CONSTANT, -1, 0, 127, 127);
      fill_uniform(0);
      send_sample();
      program_profile(MODE_CONSTANT, -1, 127, 0, 0);
      fill_uniform(0);
      send_sample();
      program_profile(MODE_PARABOLIC, 1, 0, 0, 127);
      fill_uniform(0);
      send_sample();

      // --- random pass: light idling, heavy idling, then back to back ---
      foreach (patterns[p]) begin
         idle_pct = patterns[p];
         for (int s = 0; s < RANDOM_SETS; s++) begin
            program_profile($urandom_range(1) ? MODE_PARABOLIC : MODE_CONSTANT,
                            random_target(), random_power(), random_power(),
                            random_power());
            for (int n = 0; n < RANDOM_RUN; n++) begin
               build_random_sample();
               send_sample();
            end
         end
      end

      // drain, then watch a little longer for stray strobes
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d encoder samples through %0d profiles (both modes, register extremes).",
               samples_sent, profiles_used);
      $display("Compared %0d drive commands with their predictions.", results_checked);
      if (fail_count == 0)
         $display("drive_distance_power_profiler_unit test passed");
      else
         $display("drive_distance_power_profiler_unit test failed");
      $finish;
   end

endmodule

### files.f
src/ddpp_pkg.sv
src/ddpp_dist.sv
src/ddpp_div_step.sv
src/ddpp_ramp.sv
src/drive_distance_power_profiler_unit.sv
dv/ddpp_drive_checker.sv
dv/tb.sv
